// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the top level rtl
// each macro expects clk and rst to be in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/svps_pkg.sv -----
// types and constants for the stochastic volatility path step
// no dependencies
`default_nettype none

package svps_pkg;

  // field widths
  localparam int PRICE_W    = 41;
  localparam int VAR_W      = 32;
  localparam int VOL_W      = 31;
  localparam int STEP_W     = 16;
  localparam int NORMAL_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_PRICE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_VARIANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSION      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_RUN_VAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_OF_VOL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORRELATION    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NET_RATE       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 3'd7;

  // register reset values
  localparam logic [39:0]        RST_START_PRICE    = 40'd1677721600;
  localparam logic [30:0]        RST_START_VARIANCE = 31'd671089;
  localparam logic [30:0]        RST_REVERSION      = 31'd33554432;
  localparam logic [30:0]        RST_LONG_RUN_VAR   = 31'd671089;
  localparam logic [30:0]        RST_VOL_OF_VOL     = 31'd5033165;
  localparam logic signed [25:0] RST_CORRELATION    = -26'sd11744051;
  localparam logic signed [31:0] RST_NET_RATE       = 32'sd838861;
  localparam logic [24:0]        RST_TIME_STEP      = 25'd66577;

  // fixed point one and minus one
  localparam logic signed [25:0] RHO_MAX  = 26'sd16777216;
  localparam logic signed [25:0] RHO_MIN  = -26'sd16777216;
  localparam logic [24:0]        DT_MAX   = 25'd16777216;

  // saturation bounds on the 51-bit sum
  localparam logic signed [50:0] VAR_HI   = 51'sd2147483647;
  localparam logic signed [50:0] VAR_LO   = -51'sd2147483648;
  localparam logic signed [50:0] PRICE_HI = 51'sd1099511627775;
  localparam logic signed [50:0] PRICE_LO = -51'sd1099511627776;

  // shared unit sequencing
  localparam logic [4:0] MUL_LAST  = 5'd3;
  localparam logic [4:0] SQRT_LAST = 5'd29;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RR,
    ST_RS,
    ST_RA,
    ST_RV,
    ST_W2A,
    ST_W2B,
    ST_DV1,
    ST_DV2,
    ST_NV1,
    ST_NV2,
    ST_NV3,
    ST_DS1,
    ST_DS2,
    ST_NS1,
    ST_NS2,
    ST_NS3,
    ST_VOL
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stochastic_volatility_path_step_top.sv -----
// heston euler-maruyama path step: one shared multiplier and one square root unit
// depends on svps_pkg and assert_macros.svh
//
// input channel: normal_a, normal_b, restart with in_valid / in_stall; a transaction
// moves one step request. output channel: price, variance, volatility, step_index
// with out_valid / out_stall, one result transaction per request.
// the result is loaded into the output register at the end of the final square
// root; restart adds one multiply and two extra square roots to the step.
// the block takes one request at a time; in_stall is high from acceptance until
// the result has been loaded into the output register, so the next request can
// enter the cycle after that. the step length is set by the 48x16 multiplier
// (12 or 13 rescaled products per step) and the one-bit-per-cycle square root
// (2 or 4 per step).
// the output register holds a result while out_stall is high; a finished step
// waits for it to empty, and a new request is taken while a result is waiting.
// reset (rst, synchronous) loads the register defaults, reloads price and
// variance from the start defaults and clears the roots and the step count, so
// steps before the first restart carry drift only.
// configuration is to be written through cfg_we / cfg_index / cfg_data only when idle; the block does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module stochastic_volatility_path_step_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [svps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [svps_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [svps_pkg::NORMAL_W-1:0]   normal_a,
  input  wire logic signed [svps_pkg::NORMAL_W-1:0]   normal_b,
  input  wire logic                                   restart,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [svps_pkg::PRICE_W-1:0]         price,
  output logic signed [svps_pkg::VAR_W-1:0]           variance,
  output logic [svps_pkg::VOL_W-1:0]                  volatility,
  output logic [svps_pkg::STEP_W-1:0]                 step_index
);
  import svps_pkg::*;

  // configuration registers
  logic [39:0]        start_price;
  logic [30:0]        start_variance;
  logic [30:0]        reversion_speed;
  logic [30:0]        long_run_variance;
  logic [30:0]        vol_of_vol;
  logic signed [25:0] correlation;
  logic signed [31:0] net_rate;
  logic [24:0]        time_step;

  // path state
  logic signed [40:0] price_reg;
  logic signed [31:0] variance_reg;
  logic [24:0]        root_step;
  logic [24:0]        root_anti;
  logic [15:0]        step_counter;
  logic [15:0]        step_counter_next;

  // per-step working registers
  logic signed [15:0] za;
  logic signed [15:0] zb;
  logic [27:0]        rootv;
  logic signed [17:0] w2;
  logic signed [48:0] tmp;
  logic signed [50:0] total;

  // sequencer
  state_t     state;
  state_t     state_next;
  logic [4:0] cnt;

  // shared multiplier
  logic [47:0]        mag_a;
  logic [31:0]        mag_b;
  logic               mneg;
  logic               msh12;
  logic [79:0]        acc;
  logic [15:0]        b_chunk;
  logic [63:0]        pp;
  logic [47:0]        res_mag;
  logic signed [48:0] mul_res;

  // shared square root
  logic [55:0] sq_x;
  logic [29:0] sq_rem;
  logic [27:0] sq_root;
  logic [31:0] sq_cand;
  logic [31:0] sq_trial;
  logic        sq_ge;

  // decoded control
  logic               is_mul;
  logic               is_sqrt;
  logic               sh12;
  logic signed [48:0] op_a;
  logic signed [32:0] op_b;
  logic [48:0]        abs_a;
  logic [32:0]        abs_b;
  logic [30:0]        sq_in;
  logic               op_last;
  logic               advance;
  logic               accept;

  // derived operands
  logic signed [25:0] rho_c;
  logic [24:0]        dtc;
  logic [30:0]        vpos;
  logic signed [32:0] diff;
  logic [24:0]        anti_in;
  logic signed [50:0] sum_next;
  logic signed [31:0] var_sat;
  logic signed [40:0] price_sat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  assign rho_c   = (correlation > RHO_MAX) ? RHO_MAX :
                   (correlation < RHO_MIN) ? RHO_MIN : correlation;
  assign dtc     = (time_step > DT_MAX) ? DT_MAX : time_step;
  assign vpos    = variance_reg[31] ? '0 : variance_reg[30:0];
  assign diff    = $signed({2'b00, long_run_variance}) - $signed({2'b00, vpos});
  assign anti_in = DT_MAX - tmp[24:0];

  assign step_counter_next = (step_counter == '1) ? step_counter : step_counter + 16'd1;

  // operand select and unit decode
  always_comb begin
    is_mul  = 1'b0;
    is_sqrt = 1'b0;
    sh12    = 1'b0;
    op_a    = '0;
    op_b    = '0;
    sq_in   = '0;
    unique case (state)
      ST_IDLE: ;
      ST_RR: begin
        is_mul = 1'b1;
        op_a   = 49'(rho_c);
        op_b   = 33'(rho_c);
      end
      ST_RS: begin
        is_sqrt = 1'b1;
        sq_in   = 31'(dtc);
      end
      ST_RA: begin
        is_sqrt = 1'b1;
        sq_in   = 31'(anti_in);
      end
      ST_RV: begin
        is_sqrt = 1'b1;
        sq_in   = vpos;
      end
      ST_W2A: begin
        is_mul = 1'b1;
        op_a   = 49'(rho_c);
        op_b   = 33'(za);
      end
      ST_W2B: begin
        is_mul = 1'b1;
        op_a   = 49'(root_anti);
        op_b   = 33'(zb);
      end
      ST_DV1: begin
        is_mul = 1'b1;
        op_a   = 49'(reversion_speed);
        op_b   = diff;
      end
      ST_DV2: begin
        is_mul = 1'b1;
        op_a   = tmp;
        op_b   = 33'(dtc);
      end
      ST_NV1: begin
        is_mul = 1'b1;
        op_a   = 49'(vol_of_vol);
        op_b   = 33'(rootv);
      end
      ST_NV2: begin
        is_mul = 1'b1;
        op_a   = tmp;
        op_b   = 33'(root_step);
      end
      ST_NV3: begin
        is_mul = 1'b1;
        sh12   = 1'b1;
        op_a   = tmp;
        op_b   = 33'(w2);
      end
      ST_DS1: begin
        is_mul = 1'b1;
        op_a   = 49'(price_reg);
        op_b   = 33'(net_rate);
      end
      ST_DS2: begin
        is_mul = 1'b1;
        op_a   = tmp;
        op_b   = 33'(dtc);
      end
      ST_NS1: begin
        is_mul = 1'b1;
        op_a   = 49'(price_reg);
        op_b   = 33'(rootv);
      end
      ST_NS2: begin
        is_mul = 1'b1;
        op_a   = tmp;
        op_b   = 33'(root_step);
      end
      ST_NS3: begin
        is_mul = 1'b1;
        sh12   = 1'b1;
        op_a   = tmp;
        op_b   = 33'(za);
      end
      ST_VOL: begin
        is_sqrt = 1'b1;
        sq_in   = variance_reg[31] ? '0 : variance_reg[30:0];
      end
    endcase
  end

  assign op_last = (is_mul && cnt == MUL_LAST) || (is_sqrt && cnt == SQRT_LAST);
  // the last step waits for the output register to be free
  assign advance = op_last && ((state != ST_VOL) || !out_valid || !out_stall);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = restart ? ST_RR : ST_RV;
      ST_RR:   if (advance) state_next = ST_RS;
      ST_RS:   if (advance) state_next = ST_RA;
      ST_RA:   if (advance) state_next = ST_RV;
      ST_RV:   if (advance) state_next = ST_W2A;
      ST_W2A:  if (advance) state_next = ST_W2B;
      ST_W2B:  if (advance) state_next = ST_DV1;
      ST_DV1:  if (advance) state_next = ST_DV2;
      ST_DV2:  if (advance) state_next = ST_NV1;
      ST_NV1:  if (advance) state_next = ST_NV2;
      ST_NV2:  if (advance) state_next = ST_NV3;
      ST_NV3:  if (advance) state_next = ST_DS1;
      ST_DS1:  if (advance) state_next = ST_DS2;
      ST_DS2:  if (advance) state_next = ST_NS1;
      ST_NS1:  if (advance) state_next = ST_NS2;
      ST_NS2:  if (advance) state_next = ST_NS3;
      ST_NS3:  if (advance) state_next = ST_VOL;
      ST_VOL:  if (advance) state_next = ST_IDLE;
    endcase
  end

  // multiplier datapath: sign-magnitude, two 16-bit chunks of b
  assign abs_a   = op_a[48] ? 49'(-op_a) : op_a;
  assign abs_b   = op_b[32] ? 33'(-op_b) : op_b;
  assign b_chunk = (cnt == 5'd1) ? mag_b[15:0] : mag_b[31:16];
  assign pp      = mag_a * b_chunk;
  assign res_mag = msh12 ? acc[12 +: 48] : acc[24 +: 48];
  assign mul_res = mneg ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});

  assign sum_next  = total + 51'(mul_res);
  assign var_sat   = (sum_next > VAR_HI) ? 32'(VAR_HI) :
                     (sum_next < VAR_LO) ? 32'(VAR_LO) : sum_next[31:0];
  assign price_sat = (sum_next > PRICE_HI) ? 41'(PRICE_HI) :
                     (sum_next < PRICE_LO) ? 41'(PRICE_LO) : sum_next[40:0];

  // square root datapath: one result bit per cycle
  assign sq_cand  = {sq_rem, sq_x[55:54]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign sq_ge    = (sq_cand >= sq_trial);

  always_ff @(posedge clk) begin
    if (is_mul) begin
      unique case (cnt)
        5'd0: begin
          mag_a <= abs_a[47:0];
          mag_b <= abs_b[31:0];
          mneg  <= op_a[48] ^ op_b[32];
          msh12 <= sh12;
          acc   <= sh12 ? (80'd1 << 11) : (80'd1 << 23);
        end
        5'd1: acc <= acc + {16'd0, pp};
        5'd2: acc <= acc + {pp, 16'd0};
        default: ;
      endcase
    end
    if (is_sqrt) begin
      if (cnt == 5'd0) begin
        sq_x    <= {1'b0, sq_in, 24'd0};
        sq_rem  <= '0;
        sq_root <= '0;
      end else if (cnt != SQRT_LAST) begin
        sq_x    <= {sq_x[53:0], 2'b00};
        sq_rem  <= sq_ge ? 30'(sq_cand - sq_trial) : sq_cand[29:0];
        sq_root <= {sq_root[26:0], sq_ge};
      end
    end
  end

  // working registers: normals captured on acceptance, results written at the end of an operation
  always_ff @(posedge clk) begin
    if (accept) begin
      za <= normal_a;
      zb <= normal_b;
    end
    if (advance) begin
      unique case (state)
        ST_RR, ST_DV1, ST_NV1, ST_NV2, ST_DS1, ST_NS1, ST_NS2: tmp <= mul_res;
        ST_RV:  rootv <= sq_root;
        ST_W2A: w2 <= mul_res[17:0];
        ST_W2B: w2 <= w2 + mul_res[17:0];
        ST_DV2: total <= 51'(variance_reg) + 51'(mul_res);
        ST_DS2: total <= 51'(price_reg) + 51'(mul_res);
        default: ;
      endcase
    end
  end

  // control, configuration and path state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      cnt               <= '0;
      out_valid         <= 1'b0;
      start_price       <= RST_START_PRICE;
      start_variance    <= RST_START_VARIANCE;
      reversion_speed   <= RST_REVERSION;
      long_run_variance <= RST_LONG_RUN_VAR;
      vol_of_vol        <= RST_VOL_OF_VOL;
      correlation       <= RST_CORRELATION;
      net_rate          <= RST_NET_RATE;
      time_step         <= RST_TIME_STEP;
      price_reg         <= 41'(RST_START_PRICE);
      variance_reg      <= 32'(RST_START_VARIANCE);
      root_step         <= '0;
      root_anti         <= '0;
      step_counter      <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE || advance) begin
        cnt <= '0;
      end else if (!op_last) begin
        cnt <= cnt + 5'd1;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_PRICE:    start_price       <= cfg_data[39:0];
          REG_START_VARIANCE: start_variance    <= cfg_data[30:0];
          REG_REVERSION:      reversion_speed   <= cfg_data[30:0];
          REG_LONG_RUN_VAR:   long_run_variance <= cfg_data[30:0];
          REG_VOL_OF_VOL:     vol_of_vol        <= cfg_data[30:0];
          REG_CORRELATION:    correlation       <= cfg_data[25:0];
          REG_NET_RATE:       net_rate          <= cfg_data[31:0];
          REG_TIME_STEP:      time_step         <= cfg_data[24:0];
        endcase
      end

      if (accept && restart) begin
        price_reg    <= 41'(start_price);
        variance_reg <= 32'(start_variance);
        step_counter <= '0;
      end

      if (advance) begin
        unique case (state)
          ST_RS:  root_step <= sq_root[24:0];
          ST_RA:  root_anti <= sq_root[24:0];
          ST_NV3: variance_reg <= var_sat;
          ST_NS3: price_reg <= price_sat;
          ST_VOL: step_counter <= step_counter_next;
          default: ;
        endcase
      end

      if (advance && state == ST_VOL) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance && state == ST_VOL) begin
      price      <= price_reg;
      variance   <= variance_reg;
      volatility <= 31'(sq_root);
      step_index <= step_counter_next;
    end
  end

  `CHK_NEXT(a_busy_after_accept, accept, state != ST_IDLE, "not busy after input transaction")
  `CHK_IMPLY(a_mul_cnt, is_mul, cnt <= MUL_LAST, "multiplier phase out of range")
  `CHK_IMPLY(a_sqrt_cnt, is_sqrt, cnt <= SQRT_LAST, "square root phase out of range")
  `CHK_IMPLY(a_neg_var_vol, out_valid && variance[31], volatility == '0, "volatility of negative variance")
  `CHK_IMPLY(a_out_from_vol, $rose(out_valid), $past(state) == ST_VOL, "result outside final step")

endmodule

`default_nettype wire

// ----- bench/stochastic_volatility_path_step_top_test.sv -----
// testbench for the heston path step: directed and random steps checked against
// an in-bench fixed point predictor; depends on svps_pkg and the top level rtl
`default_nettype none

module stochastic_volatility_path_step_top_test;
  import svps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q24 = 64'sd1 << 24;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 250;

  typedef struct packed {
    logic signed [PRICE_W-1:0] price;
    logic signed [VAR_W-1:0]   variance;
    logic [VOL_W-1:0]          volatility;
    logic [STEP_W-1:0]         step_index;
  } path_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [NORMAL_W-1:0] normal_a = '0;
  logic signed [NORMAL_W-1:0] normal_b = '0;
  logic restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [PRICE_W-1:0] price;
  logic signed [VAR_W-1:0] variance;
  logic [VOL_W-1:0] volatility;
  logic [STEP_W-1:0] step_index;

  stochastic_volatility_path_step_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .normal_a(normal_a), .normal_b(normal_b),
    .restart(restart), .out_valid(out_valid), .out_stall(out_stall), .price(price),
    .variance(variance), .volatility(volatility), .step_index(step_index)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [CFG_DATA_W-1:0] model_cfg [8];
  longint path_price, path_var, root_dt, root_anti;
  int unsigned steps_taken;
  path_point_t pending_points [$];
  int fail_count = 0;
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit rx_hold_now = 1'b0;
  int quiet_cycles = 0;

  function automatic longint scaled_product(longint a, longint b, int sh);
    logic [127:0] p;
    logic [63:0] ua, ub;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > (128'd1 << 61)) p = 128'd1 << 61;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint root_q24(longint x);
    logic [63:0] v, r, b;
    if (x <= 0) return 0;
    v = 64'(x) << 24;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic void reset_model();
    model_cfg[REG_START_PRICE]    = 40'(RST_START_PRICE);
    model_cfg[REG_START_VARIANCE] = 40'(RST_START_VARIANCE);
    model_cfg[REG_REVERSION]      = 40'(RST_REVERSION);
    model_cfg[REG_LONG_RUN_VAR]   = 40'(RST_LONG_RUN_VAR);
    model_cfg[REG_VOL_OF_VOL]     = 40'(RST_VOL_OF_VOL);
    model_cfg[REG_CORRELATION]    = 40'(26'(RST_CORRELATION));
    model_cfg[REG_NET_RATE]       = 40'(32'(RST_NET_RATE));
    model_cfg[REG_TIME_STEP]      = 40'(RST_TIME_STEP);
    path_price = longint'(RST_START_PRICE);
    path_var = longint'(RST_START_VARIANCE);
    root_dt = 0;
    root_anti = 0;
    steps_taken = 0;
  endfunction

  function automatic path_point_t euler_step(longint za, longint zb, bit rs);
    longint rho, dt, vpos, rootv, w2, drift, noise, nv, ns, kappa, theta, sigma, rate;
    path_point_t pt;
    rho = clamp(longint'(signed'(model_cfg[REG_CORRELATION][25:0])), -ONE_Q24, ONE_Q24);
    dt = longint'(model_cfg[REG_TIME_STEP][24:0]);
    if (dt > ONE_Q24) dt = ONE_Q24;
    kappa = longint'(model_cfg[REG_REVERSION][30:0]);
    theta = longint'(model_cfg[REG_LONG_RUN_VAR][30:0]);
    sigma = longint'(model_cfg[REG_VOL_OF_VOL][30:0]);
    rate = longint'(signed'(model_cfg[REG_NET_RATE][31:0]));
    if (rs) begin
      path_price = longint'(model_cfg[REG_START_PRICE][39:0]);
      path_var = longint'(model_cfg[REG_START_VARIANCE][30:0]);
      root_dt = root_q24(dt);
      root_anti = root_q24(ONE_Q24 - scaled_product(rho, rho, 24));
      steps_taken = 0;
    end
    vpos = path_var > 0 ? path_var : 0;
    rootv = root_q24(vpos);
    w2 = scaled_product(rho, za, 24) + scaled_product(root_anti, zb, 24);
    drift = scaled_product(scaled_product(kappa, theta - vpos, 24), dt, 24);
    noise = scaled_product(scaled_product(scaled_product(sigma, rootv, 24), root_dt, 24),
                           w2, 12);
    nv = clamp(path_var + drift + noise, -(64'sd1 << 31), (64'sd1 << 31) - 1);
    drift = scaled_product(scaled_product(rate, path_price, 24), dt, 24);
    noise = scaled_product(scaled_product(scaled_product(rootv, path_price, 24), root_dt, 24),
                           za, 12);
    ns = clamp(path_price + drift + noise, -(64'sd1 << 40), (64'sd1 << 40) - 1);
    path_price = ns;
    path_var = nv;
    if (steps_taken < 65535) steps_taken++;
    pt.price = ns[PRICE_W-1:0];
    pt.variance = nv[VAR_W-1:0];
    pt.volatility = VOL_W'(root_q24(nv));
    pt.step_index = steps_taken[STEP_W-1:0];
    return pt;
  endfunction

  // ---------------- driving ----------------
  task automatic send_step(logic signed [NORMAL_W-1:0] a, logic signed [NORMAL_W-1:0] b,
                           bit rs);
    @(negedge clk);
    while (tx_idle_on && $urandom_range(99) < 35) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    normal_a = a;
    normal_b = b;
    restart = rs;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_points.insert(pending_points.size(), euler_step(longint'(a), longint'(b), rs));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    model_cfg[idx] = val;
  endtask

  function automatic logic signed [NORMAL_W-1:0] draw_normal();
    // mostly plausible normals, sometimes anything in the field
    if ($urandom_range(9) == 0) return NORMAL_W'($urandom);
    return NORMAL_W'(int'($urandom_range(0, 16383)) - 8192);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_reg(logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] r;
    int pick;
    r = 40'({$urandom, $urandom});
    pick = $urandom_range(5);
    case (idx)
      REG_START_PRICE: begin
        if (pick == 0) r = '1;
        else if (pick == 1) r = '0;
        else r = 40'($urandom_range(1, 32'h7fff_ffff)) << $urandom_range(0, 8);
      end
      REG_CORRELATION: begin
        if (pick < 2) r = 40'($urandom);
        else r = 40'(26'(int'($urandom_range(0, 33554432)) - 16777216));
      end
      REG_NET_RATE: begin
        if (pick == 0) r = 40'(32'h7fff_ffff);
        else if (pick == 1) r = 40'(32'h8000_0000);
        else r = 40'(32'(int'($urandom_range(0, 6000000)) - 3000000));
      end
      REG_TIME_STEP: begin
        if (pick == 0) r = '0;
        else if (pick == 1) r = 40'(25'h1ff_ffff);
        else r = 40'($urandom_range(1, 16777216));
      end
      default: begin
        if (pick == 0) r = 40'(31'h7fff_ffff);
        else if (pick == 1) r = '0;
        else r = 40'($urandom_range(0, 50000000));
      end
    endcase
    return r;
  endfunction

  // ---------------- receiving and checking ----------------
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_now) begin
        out_stall = 1'b1;
        repeat (600) @(negedge clk);
        rx_hold_now = 1'b0;
      end
      out_stall = rx_idle_on && ($urandom_range(99) < 35);
    end
  end

  always @(posedge clk) begin
    path_point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $display("%0t: result transaction with nothing expected: price %0d", $time, price);
        fail_count++;
      end else begin
        want = pending_points.pop_front();
        if (price !== want.price) begin
          $display("%0t: price expected %0d actual %0d", $time, want.price, price);
          fail_count++;
        end
        if (variance !== want.variance) begin
          $display("%0t: variance expected %0d actual %0d", $time, want.variance, variance);
          fail_count++;
        end
        if (volatility !== want.volatility) begin
          $display("%0t: volatility expected %0d actual %0d", $time, want.volatility,
                   volatility);
          fail_count++;
        end
        if (step_index !== want.step_index) begin
          $display("%0t: step_index expected %0d actual %0d", $time, want.step_index,
                   step_index);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_drift_before_restart();
    // roots are still zero: price and variance move by drift only
    send_step(16'sh7fff, 16'sh8000, 1'b0);
    send_step(16'sh8000, 16'sh7fff, 1'b0);
    send_step(16'sh0000, 16'sh0000, 1'b0);
  endtask

  task automatic test_extreme_normals();
    send_step(16'sh0000, 16'sh0000, 1'b1);
    send_step(16'sh7fff, 16'sh7fff, 1'b0);
    send_step(16'sh8000, 16'sh8000, 1'b0);
    send_step(16'sh7fff, 16'sh8000, 1'b0);
    send_step(16'sh1000, -16'sh1000, 1'b0);
    wait_drained();
  endtask

  task automatic test_correlation_edges();
    // beyond one in both directions, then exactly one
    write_reg(REG_CORRELATION, 40'(26'h1ff_ffff));
    send_step(16'sh1800, 16'sh0800, 1'b1);
    send_step(-16'sh1800, 16'sh0800, 1'b0);
    wait_drained();
    write_reg(REG_CORRELATION, 40'(26'h200_0000));
    send_step(16'sh1800, -16'sh0800, 1'b1);
    wait_drained();
    write_reg(REG_CORRELATION, 40'(26'h100_0000));
    send_step(16'sh0400, 16'sh7fff, 1'b1);
    wait_drained();
    // roots stay latched from the last restart while rho changes
    write_reg(REG_CORRELATION, 40'(26'(RST_CORRELATION)));
    send_step(16'sh0400, 16'sh0400, 1'b0);
    wait_drained();
  endtask

  task automatic test_time_step_edges();
    write_reg(REG_TIME_STEP, '0);
    send_step(16'sh2000, 16'sh2000, 1'b1);
    send_step(16'sh2000, 16'sh2000, 1'b0);
    wait_drained();
    write_reg(REG_TIME_STEP, 40'(25'h1ff_ffff));
    send_step(16'sh0800, -16'sh0800, 1'b1);
    send_step(-16'sh0800, 16'sh0800, 1'b0);
    wait_drained();
    write_reg(REG_TIME_STEP, 40'(RST_TIME_STEP));
  endtask

  task automatic test_negative_variance();
    write_reg(REG_VOL_OF_VOL, 40'(31'h7fff_ffff));
    write_reg(REG_CORRELATION, '0);
    send_step(16'sh0000, 16'sh8000, 1'b1);
    send_step(16'sh0100, 16'sh0100, 1'b0);
    send_step(16'sh0100, 16'sh7fff, 1'b0);
    wait_drained();
  endtask

  task automatic test_saturation();
    write_reg(REG_START_PRICE, '1);
    write_reg(REG_NET_RATE, 40'(32'h7fff_ffff));
    write_reg(REG_TIME_STEP, 40'(25'h100_0000));
    write_reg(REG_START_VARIANCE, 40'(31'h7fff_ffff));
    write_reg(REG_REVERSION, 40'(31'h7fff_ffff));
    write_reg(REG_LONG_RUN_VAR, 40'(31'h7fff_ffff));
    send_step(16'sh7fff, 16'sh7fff, 1'b1);
    send_step(16'sh8000, 16'sh8000, 1'b0);
    wait_drained();
    write_reg(REG_NET_RATE, 40'(32'h8000_0000));
    write_reg(REG_LONG_RUN_VAR, '0);
    send_step(16'sh8000, 16'sh7fff, 1'b1);
    send_step(16'sh7fff, 16'sh8000, 1'b0);
    wait_drained();
  endtask

  task automatic test_back_pressure();
    tx_idle_on = 1'b0;
    rx_hold_now = 1'b1;
    for (int i = 0; i < 12; i++) send_step(draw_normal(), draw_normal(), i == 0);
    wait_drained();
  endtask

  task automatic test_random_paths();
    for (int phase = 0; phase < 8; phase++) begin
      // one phase runs at full rate, one keeps the reset settings
      tx_idle_on = (phase != 3);
      rx_idle_on = (phase != 3);
      if (phase == 1) begin
        write_reg(REG_START_PRICE, 40'(RST_START_PRICE));
        write_reg(REG_START_VARIANCE, 40'(RST_START_VARIANCE));
        write_reg(REG_REVERSION, 40'(RST_REVERSION));
        write_reg(REG_LONG_RUN_VAR, 40'(RST_LONG_RUN_VAR));
        write_reg(REG_VOL_OF_VOL, 40'(RST_VOL_OF_VOL));
        write_reg(REG_CORRELATION, 40'(26'(RST_CORRELATION)));
        write_reg(REG_NET_RATE, 40'(32'(RST_NET_RATE)));
        write_reg(REG_TIME_STEP, 40'(RST_TIME_STEP));
      end else begin
        for (int r = 0; r < 8; r++) write_reg(CFG_IDX_W'(r), draw_reg(CFG_IDX_W'(r)));
      end
      for (int i = 0; i < 95; i++)
        send_step(draw_normal(), draw_normal(), i == 0 || $urandom_range(19) == 0);
      wait_drained();
    end
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_drift_before_restart();
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
    test_extreme_normals();
    test_correlation_edges();
    test_time_step_edges();
    test_negative_variance();
    test_saturation();
    test_back_pressure();
    test_random_paths();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
